FILE: rtl/zph_pkg.sv
package zph_pkg;

   // Fixed geometry of the board and the key table.
   localparam int BOARD_SQUARES = 64;
   localparam int SQ_W          = 6;
   localparam int KEY_WORDS     = 781;
   localparam int KEY_IDX_W     = 10;
   localparam int HASH_WIDTH    = 64;
   localparam int EP_W          = 7;
   localparam int CNT_W         = 7;

   // Transaction codes on req_action.
   localparam logic [1:0] ACT_KEY    = 2'd0;
   localparam logic [1:0] ACT_SQUARE = 2'd1;
   localparam logic [1:0] ACT_FINISH = 2'd2;

   // Piece kinds.
   localparam logic [2:0] PIECE_EMPTY = 3'd0;
   localparam logic [2:0] PIECE_PAWN  = 3'd1;
   localparam logic [2:0] PIECE_KING  = 3'd6;

   // Special key table entries.
   localparam logic [KEY_IDX_W-1:0] CASTLE_WK = 10'd768;
   localparam logic [KEY_IDX_W-1:0] CASTLE_WQ = 10'd769;
   localparam logic [KEY_IDX_W-1:0] CASTLE_BK = 10'd770;
   localparam logic [KEY_IDX_W-1:0] CASTLE_BQ = 10'd771;
   localparam logic [KEY_IDX_W-1:0] EP_BASE   = 10'd772;
   localparam logic [KEY_IDX_W-1:0] TURN_KEY  = 10'd780;

   // Corner and king squares that decide castling rights.
   localparam logic [SQ_W-1:0] SQ_A1 = 6'd0;
   localparam logic [SQ_W-1:0] SQ_E1 = 6'd4;
   localparam logic [SQ_W-1:0] SQ_H1 = 6'd7;
   localparam logic [SQ_W-1:0] SQ_A8 = 6'd56;
   localparam logic [SQ_W-1:0] SQ_E8 = 6'd60;
   localparam logic [SQ_W-1:0] SQ_H8 = 6'd63;

   // Sequencer schedule of one finish transaction.
   localparam logic [CNT_W-1:0] CNT_EXTRA_FIRST = 7'd65;
   localparam logic [CNT_W-1:0] CNT_EXTRA_LAST  = 7'd70;
   localparam logic [CNT_W-1:0] CNT_DONE        = 7'd71;

   // Extra lookups after the square walk, in issue order.
   localparam logic [2:0] STEP_CASTLE_WK = 3'd0;
   localparam logic [2:0] STEP_CASTLE_WQ = 3'd1;
   localparam logic [2:0] STEP_CASTLE_BK = 3'd2;
   localparam logic [2:0] STEP_CASTLE_BQ = 3'd3;
   localparam logic [2:0] STEP_EP        = 3'd4;
   localparam logic [2:0] STEP_TURN      = 3'd5;

   // One stored board square.
   typedef struct packed {
      logic       unmoved;
      logic       white;
      logic [2:0] kind;
   } zph_cell_type;

   typedef enum logic {
      ZPH_IDLE,
      ZPH_WALK
   } zph_state_type;

endpackage

FILE: rtl/zph_ram.sv
module zph_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/zobrist_position_hash_unit.sv
// Zobrist position hash. Each transaction either writes one key word, writes
// one board square, or asks for the hash of the stored position. Writes are
// accepted while idle and do not make the block busy, so they may be issued
// back to back. A finish keeps busy high through the walk, and nothing is
// taken while busy; the result strobe comes in the first cycle in which busy
// is low again, and the next transaction may be started in that same cycle.
// The walk length is set by the single read port of the key table: 64 square
// lookups, six castling, en passant and turn lookups and pipeline fill. The
// result is shown on rsp_hash for exactly one cycle while rsp_strobe is high;
// the receiver cannot stall it and must take it then. The board starts empty
// after reset through per-square valid bits, so no clearing pass is needed.
// Key words must be written before a finish reads them.
module zobrist_position_hash_unit
   import zph_pkg::*;
#(
   parameter int KEY_WIDTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_action,
   input  logic [KEY_IDX_W-1:0]  req_table_index,
   input  logic [HASH_WIDTH-1:0] req_key_word,
   input  logic [SQ_W-1:0]       req_place,
   input  logic [2:0]            req_piece_kind,
   input  logic                  req_piece_white,
   input  logic                  req_piece_unmoved,
   input  logic                  req_side_white,
   input  logic [EP_W-1:0]       req_ep_square,
   output logic                  rsp_strobe,
   output logic [HASH_WIDTH-1:0] rsp_hash
);

   zph_state_type state_ff, state_in;
   logic [CNT_W-1:0] walk_cnt_ff, walk_cnt_in;
   logic [KEY_WIDTH-1:0] acc_ff, acc_in;
   logic rsp_strobe_ff, rsp_strobe_in;

   // Finish parameters held for the walk.
   logic side_ff, side_in;
   logic [2:0] ep_file_ff, ep_file_in;
   logic [SQ_W-1:0] nbr_a_ff, nbr_a_in, nbr_b_ff, nbr_b_in;
   logic nbr_a_en_ff, nbr_a_en_in, nbr_b_en_ff, nbr_b_en_in;
   logic pawn_hit_ff, pawn_hit_in;

   // Pipeline flags of the two memory reads.
   logic b_vld_ff, b_vld_in;
   logic [SQ_W-1:0] b_sq_ff, b_sq_in;
   logic k_vld_ff, k_vld_in;

   // Board valid bits and the unmoved flags of the castling squares.
   logic [BOARD_SQUARES-1:0] board_valid_ff, board_valid_in;
   logic unm_a1_ff, unm_e1_ff, unm_h1_ff, unm_a8_ff, unm_e8_ff, unm_h8_ff;
   logic unm_a1_in, unm_e1_in, unm_h1_in, unm_a8_in, unm_e8_in, unm_h8_in;

   // Memory ports.
   logic key_we, key_re, board_we, board_re;
   logic [KEY_IDX_W-1:0] key_raddr;
   logic [KEY_WIDTH-1:0] key_rdata;
   logic [SQ_W-1:0] board_raddr;
   logic [4:0] board_rdata;
   zph_cell_type wr_cell, board_cell;

   logic accept, extra_rd;
   logic [2:0] step, kind_m1;
   logic [EP_W-1:0] ep_plus7, ep_plus9, ep_minus7, ep_minus9;

   assign accept  = start && (state_ff == ZPH_IDLE);
   assign wr_cell = '{unmoved: req_piece_unmoved, white: req_piece_white,
                      kind: req_piece_kind};

   // Neighbor squares of the en passant target.
   assign ep_plus7  = req_ep_square + 7'd7;
   assign ep_plus9  = req_ep_square + 7'd9;
   assign ep_minus7 = req_ep_square - 7'd7;
   assign ep_minus9 = req_ep_square - 7'd9;

   // Square data arriving from the board; a never written square is empty.
   assign board_cell = board_valid_ff[b_sq_ff] ? zph_cell_type'(board_rdata) : '0;
   assign kind_m1    = board_cell.kind - 3'd1;
   assign step       = 3'(walk_cnt_ff - CNT_EXTRA_FIRST);

   zph_ram #(
      .WIDTH (KEY_WIDTH),
      .DEPTH (KEY_WORDS)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (req_table_index),
      .wr_data (req_key_word[KEY_WIDTH-1:0]),
      .rd_en   (key_re),
      .rd_addr (key_raddr),
      .rd_data (key_rdata)
   );

   zph_ram #(
      .WIDTH (5),
      .DEPTH (BOARD_SQUARES)
   ) u_board_ram (
      .clock   (clock),
      .wr_en   (board_we),
      .wr_addr (req_place),
      .wr_data (wr_cell),
      .rd_en   (board_re),
      .rd_addr (board_raddr),
      .rd_data (board_rdata)
   );

   // State and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ZPH_IDLE;
         walk_cnt_ff    <= '0;
         acc_ff         <= '0;
         rsp_strobe_ff  <= 1'b0;
         b_vld_ff       <= 1'b0;
         k_vld_ff       <= 1'b0;
         board_valid_ff <= '0;
         unm_a1_ff      <= 1'b0;
         unm_e1_ff      <= 1'b0;
         unm_h1_ff      <= 1'b0;
         unm_a8_ff      <= 1'b0;
         unm_e8_ff      <= 1'b0;
         unm_h8_ff      <= 1'b0;
      end else begin
         state_ff       <= state_in;
         walk_cnt_ff    <= walk_cnt_in;
         acc_ff         <= acc_in;
         rsp_strobe_ff  <= rsp_strobe_in;
         b_vld_ff       <= b_vld_in;
         k_vld_ff       <= k_vld_in;
         board_valid_ff <= board_valid_in;
         unm_a1_ff      <= unm_a1_in;
         unm_e1_ff      <= unm_e1_in;
         unm_h1_ff      <= unm_h1_in;
         unm_a8_ff      <= unm_a8_in;
         unm_e8_ff      <= unm_e8_in;
         unm_h8_ff      <= unm_h8_in;
      end
   end

   // Payload registers of the walk.
   always_ff @(posedge clock) begin
      side_ff     <= side_in;
      ep_file_ff  <= ep_file_in;
      nbr_a_ff    <= nbr_a_in;
      nbr_b_ff    <= nbr_b_in;
      nbr_a_en_ff <= nbr_a_en_in;
      nbr_b_en_ff <= nbr_b_en_in;
      pawn_hit_ff <= pawn_hit_in;
      b_sq_ff     <= b_sq_in;
   end

   // Sequencer: next state, memory controls and accumulation.
   always_comb begin
      state_in       = state_ff;
      walk_cnt_in    = walk_cnt_ff;
      acc_in         = acc_ff;
      rsp_strobe_in  = 1'b0;
      side_in        = side_ff;
      ep_file_in     = ep_file_ff;
      nbr_a_in       = nbr_a_ff;
      nbr_b_in       = nbr_b_ff;
      nbr_a_en_in    = nbr_a_en_ff;
      nbr_b_en_in    = nbr_b_en_ff;
      pawn_hit_in    = pawn_hit_ff;
      board_valid_in = board_valid_ff;
      unm_a1_in      = unm_a1_ff;
      unm_e1_in      = unm_e1_ff;
      unm_h1_in      = unm_h1_ff;
      unm_a8_in      = unm_a8_ff;
      unm_e8_in      = unm_e8_ff;
      unm_h8_in      = unm_h8_ff;
      key_we         = 1'b0;
      board_we       = 1'b0;
      board_re       = 1'b0;
      board_raddr    = walk_cnt_ff[SQ_W-1:0];
      key_re         = 1'b0;
      key_raddr      = {kind_m1, board_cell.white, b_sq_ff};
      extra_rd       = 1'b0;
      busy           = 1'b0;

      // Key data returned from the table folds into the hash.
      if (k_vld_ff) begin
         acc_in = acc_ff ^ key_rdata;
      end

      unique case (state_ff)
         ZPH_IDLE: begin
            if (accept) begin
               unique case (req_action)
                  ACT_KEY: begin
                     key_we = (req_table_index < KEY_IDX_W'(KEY_WORDS));
                  end
                  ACT_SQUARE: begin
                     board_we                  = 1'b1;
                     board_valid_in[req_place] = 1'b1;
                     if (req_place == SQ_A1) unm_a1_in = req_piece_unmoved;
                     if (req_place == SQ_E1) unm_e1_in = req_piece_unmoved;
                     if (req_place == SQ_H1) unm_h1_in = req_piece_unmoved;
                     if (req_place == SQ_A8) unm_a8_in = req_piece_unmoved;
                     if (req_place == SQ_E8) unm_e8_in = req_piece_unmoved;
                     if (req_place == SQ_H8) unm_h8_in = req_piece_unmoved;
                  end
                  ACT_FINISH: begin
                     state_in    = ZPH_WALK;
                     walk_cnt_in = '0;
                     acc_in      = '0;
                     pawn_hit_in = 1'b0;
                     side_in     = req_side_white;
                     ep_file_in  = req_ep_square[2:0];
                     // White captures from below, black from above.
                     if (req_side_white) begin
                        nbr_a_in    = ep_minus7[SQ_W-1:0];
                        nbr_b_in    = ep_minus9[SQ_W-1:0];
                        nbr_a_en_in = !req_ep_square[SQ_W] &&
                                      (req_ep_square[2:0] != 3'd7) &&
                                      (req_ep_square >= 7'd7);
                        nbr_b_en_in = !req_ep_square[SQ_W] &&
                                      (req_ep_square[2:0] != 3'd0) &&
                                      (req_ep_square >= 7'd9);
                     end else begin
                        nbr_a_in    = ep_plus7[SQ_W-1:0];
                        nbr_b_in    = ep_plus9[SQ_W-1:0];
                        nbr_a_en_in = !req_ep_square[SQ_W] &&
                                      (req_ep_square[2:0] != 3'd0) &&
                                      !ep_plus7[SQ_W];
                        nbr_b_en_in = !req_ep_square[SQ_W] &&
                                      (req_ep_square[2:0] != 3'd7) &&
                                      !ep_plus9[SQ_W];
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ZPH_WALK: begin
            busy        = 1'b1;
            walk_cnt_in = walk_cnt_ff + 7'd1;

            // First stage: read one board square per cycle.
            board_re = (walk_cnt_ff < 7'(BOARD_SQUARES));

            // Second stage: look up the piece key and watch for capturing pawns.
            if (b_vld_ff) begin
               key_re = (board_cell.kind != PIECE_EMPTY) && (board_cell.kind <= PIECE_KING);
               if ((board_cell.kind == PIECE_PAWN) && (board_cell.white == side_ff) &&
                   ((nbr_a_en_ff && (b_sq_ff == nbr_a_ff)) ||
                    (nbr_b_en_ff && (b_sq_ff == nbr_b_ff)))) begin
                  pawn_hit_in = 1'b1;
               end
            end

            // After the walk: castling, en passant and turn keys.
            if ((walk_cnt_ff >= CNT_EXTRA_FIRST) && (walk_cnt_ff <= CNT_EXTRA_LAST)) begin
               extra_rd = 1'b1;
               unique case (step)
                  STEP_CASTLE_WK: begin
                     key_re    = unm_e1_ff && unm_h1_ff;
                     key_raddr = CASTLE_WK;
                  end
                  STEP_CASTLE_WQ: begin
                     key_re    = unm_e1_ff && unm_a1_ff;
                     key_raddr = CASTLE_WQ;
                  end
                  STEP_CASTLE_BK: begin
                     key_re    = unm_e8_ff && unm_h8_ff;
                     key_raddr = CASTLE_BK;
                  end
                  STEP_CASTLE_BQ: begin
                     key_re    = unm_e8_ff && unm_a8_ff;
                     key_raddr = CASTLE_BQ;
                  end
                  STEP_EP: begin
                     key_re    = pawn_hit_ff;
                     key_raddr = EP_BASE + KEY_IDX_W'(ep_file_ff);
                  end
                  STEP_TURN: begin
                     key_re    = side_ff;
                     key_raddr = TURN_KEY;
                  end
                  default: begin
                  end
               endcase
            end

            // The last key has landed; show the result next cycle.
            if (walk_cnt_ff == CNT_DONE) begin
               state_in      = ZPH_IDLE;
               walk_cnt_in   = '0;
               rsp_strobe_in = 1'b1;
            end
         end
         default: begin
            state_in = ZPH_IDLE;
         end
      endcase
   end

   assign b_vld_in = board_re;
   assign b_sq_in  = walk_cnt_ff[SQ_W-1:0];
   assign k_vld_in = key_re;

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_hash   = HASH_WIDTH'(acc_ff);

   // A result only ever follows the last cycle of a walk.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff == ZPH_WALK))
      else $error("result strobe without a finished walk");

   // Square lookups and the trailing lookups never share the key read port.
   assert property (@(posedge clock) disable iff (reset)
      !(b_vld_ff && extra_rd))
      else $error("key table read port collision");

   // An accepted finish makes the block busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_action == ACT_FINISH)) |=> busy)
      else $error("finish accepted but block not busy");

   // The walk counter rests at zero while idle.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ZPH_IDLE) |-> (walk_cnt_ff == '0))
      else $error("walk counter not cleared after finish");

endmodule
